// ===== rtl/c3s2_pkg.sv =====
`default_nettype none
package c3s2_pkg;

  localparam int LINE_WIDTH   = 64;
  localparam int IMAGE_HEIGHT = 64;
  localparam int COL_W        = $clog2(LINE_WIDTH);
  localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
  localparam int OUT_W        = (LINE_WIDTH - 3) / 2 + 1;
  localparam int OUT_H        = (IMAGE_HEIGHT - 3) / 2 + 1;
  localparam int NUM_REGS     = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int PSUM_W       = 10;
  localparam int PROD_W       = 27;
  localparam int ACC_W        = 34;
  localparam int SUM_W        = 35;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_F0_ROW0 = 3'd0,
    REG_F0_ROW1 = 3'd1,
    REG_F0_ROW2 = 3'd2,
    REG_F1_ROW0 = 3'd3,
    REG_F1_ROW1 = 3'd4,
    REG_F1_ROW2 = 3'd5,
    REG_BIAS_0  = 3'd6,
    REG_BIAS_1  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [30:0] out_value_0;
    logic [30:0] out_value_1;
    logic [4:0]  out_row;
    logic [4:0]  out_col;
    logic        last_of_frame;
  } result_t;

  // position info that travels alongside the lane pipeline
  typedef struct packed {
    logic       valid;
    logic [4:0] orow;
    logic [4:0] ocol;
    logic       last;
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/c3s2_ram.sv =====
`default_nettype none
module c3s2_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/c3s2_lane.sv =====
`default_nettype none
// One filter: nine multiplies, registered, then a registered add tree,
// bias, ReLU and saturation.
module c3s2_lane (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic [2:0][2:0][c3s2_pkg::PSUM_W-1:0]   psum,
  input  wire logic [2:0][47:0]                        kern,
  input  wire logic signed [31:0]                      bias,
  output logic [30:0]                                  value
);
  logic signed [c3s2_pkg::PROD_W-1:0] prod [9];
  logic signed [c3s2_pkg::ACC_W-1:0]  part [3];
  logic signed [c3s2_pkg::SUM_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          prod[k*3+l] <= c3s2_pkg::PROD_W'($signed(kern[k][16*l +: 16]) *
                         $signed({1'b0, psum[k][l]}));
        end
      end
      for (int k = 0; k < 3; k++) begin
        part[k] <= c3s2_pkg::ACC_W'(prod[k*3]) + c3s2_pkg::ACC_W'(prod[k*3+1])
                   + c3s2_pkg::ACC_W'(prod[k*3+2]);
      end
      total <= c3s2_pkg::SUM_W'(part[0]) + c3s2_pkg::SUM_W'(part[1])
               + c3s2_pkg::SUM_W'(part[2]) + c3s2_pkg::SUM_W'(bias);
      if (total <= 0) value <= '0;
      else if (total > c3s2_pkg::SUM_W'(32'sh7FFF_FFFF)) value <= '1;
      else value <= total[30:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/conv3x3_stride2_bias_relu_unit.sv =====
`default_nettype none
// 3x3 stride-2 convolution, two filters, bias and ReLU, over RGB pixels.
// in: one pixel per transfer (in_valid/in_stall), raster order; frame_start
//   restarts the row and column count at zero.
// out: one result per even-aligned full window (out_valid/out_stall),
//   both filter values with output row and column.
// cfg: cfg_valid/cfg_ready write of kernel rows (0..5) and biases (6, 7);
//   write only while idle.
// Throughput: one pixel per clock while in_stall is low. A pixel that
//   completes a window passes the input register, window register, lane
//   multiply, two add stages, ReLU register and output queue.
// Both filters run as parallel lanes; the output stage merges their values
// with the position tag into a 2-entry skid queue.
// When out_stall holds, the pipeline freezes once the queue would overflow;
// in_stall then rises. Reset clears counters, config and valid bits; the
// line stores need no clearing since the counters never read unwritten rows.
module conv3x3_stride2_bias_relu_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire c3s2_pkg::pixel_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output c3s2_pkg::result_t                        out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [c3s2_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [c3s2_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int PIPE = 5;

  logic [5:0][47:0] kern;
  logic signed [31:0] bias_0, bias_1;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kern <= '0; bias_0 <= '0; bias_1 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        c3s2_pkg::REG_BIAS_0: bias_0 <= cfg_data[31:0];
        c3s2_pkg::REG_BIAS_1: bias_1 <= cfg_data[31:0];
        default: kern[cfg_index] <= cfg_data;
      endcase
    end
  end

  // pipeline advances unless the last stage holds a result the full queue
  // cannot take this cycle
  logic en;
  logic [1:0] qcount;
  logic [PIPE-1:0] vpipe;
  assign en = !vpipe[PIPE-1] || (qcount != 2'd2) || !out_stall;
  assign in_stall = !en;
  wire acc = in_valid && en;

  // stage 0: counters and line-store read
  logic [c3s2_pkg::COL_W-1:0] col;
  logic [c3s2_pkg::ROW_W-1:0] row;
  logic [c3s2_pkg::COL_W-1:0] c_cur;
  logic [c3s2_pkg::ROW_W-1:0] r_cur;
  assign c_cur = in_data.frame_start ? '0 : col;
  assign r_cur = in_data.frame_start ? '0 : row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0;
    end else if (acc) begin
      if (32'(c_cur) == c3s2_pkg::LINE_WIDTH - 1) begin
        col <= '0;
        row <= (32'(r_cur) == c3s2_pkg::IMAGE_HEIGHT - 1) ? '0 : r_cur + 1'b1;
      end else begin
        col <= c_cur + 1'b1;
        row <= r_cur;
      end
    end
  end

  logic [23:0] top_q, mid_q;
  logic [23:0] px1;
  logic [c3s2_pkg::COL_W-1:0] c1;
  logic [c3s2_pkg::ROW_W-1:0] r1;
  logic v1;
  logic [23:0] top_v, mid_v;

  c3s2_ram #(.WIDTH(24), .DEPTH(c3s2_pkg::LINE_WIDTH)) u_top (
    .clk(clk), .we(v1 && en), .waddr(c1), .wdata(mid_v),
    .re(acc), .raddr(c_cur), .rdata(top_q));
  c3s2_ram #(.WIDTH(24), .DEPTH(c3s2_pkg::LINE_WIDTH)) u_mid (
    .clk(clk), .we(v1 && en), .waddr(c1), .wdata(px1),
    .re(acc), .raddr(c_cur), .rdata(mid_q));

  // read-after-write bypass for back-to-back same column (LINE_WIDTH small)
  logic byp;
  logic [23:0] byp_mid, byp_px;
  assign top_v = byp ? byp_mid : top_q;
  assign mid_v = byp ? byp_px  : mid_q;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= acc;
    if (en) begin
      px1 <= {in_data.blue, in_data.green, in_data.red};
      c1 <= c_cur; r1 <= r_cur;
      byp <= v1 && (c1 == c_cur);
      byp_mid <= mid_v; byp_px <= px1;
    end
  end

  // stage 1: window shift, pixel sums, tag
  logic [2:0][2:0][c3s2_pkg::PSUM_W-1:0] win;
  c3s2_pkg::tag_t tag [PIPE];

  function automatic logic [c3s2_pkg::PSUM_W-1:0] psum(input logic [23:0] p);
    psum = c3s2_pkg::PSUM_W'(p[7:0]) + c3s2_pkg::PSUM_W'(p[15:8])
           + c3s2_pkg::PSUM_W'(p[23:16]);
  endfunction

  c3s2_pkg::tag_t t1;
  always_comb begin
    logic [c3s2_pkg::ROW_W-1:0] rr;
    logic [c3s2_pkg::COL_W-1:0] cc;
    rr = r1 - c3s2_pkg::ROW_W'(2);
    cc = c1 - c3s2_pkg::COL_W'(2);
    t1.orow = 5'(rr >> 1);
    t1.ocol = 5'(cc >> 1);
    t1.valid = v1 && r1 >= 2 && c1 >= 2 && !rr[0] && !cc[0]
               && 32'(rr >> 1) < c3s2_pkg::OUT_H && 32'(cc >> 1) < c3s2_pkg::OUT_W;
    t1.last = 32'(rr >> 1) == c3s2_pkg::OUT_H - 1 && 32'(cc >> 1) == c3s2_pkg::OUT_W - 1;
  end

  always_ff @(posedge clk) begin
    if (en && v1) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= psum(top_v);
      win[1][2] <= psum(mid_v);
      win[2][2] <= psum(px1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (en) vpipe <= {vpipe[PIPE-2:0], t1.valid};
    if (en) begin
      tag[0] <= t1;
      for (int i = 1; i < PIPE; i++) tag[i] <= tag[i-1];
    end
  end

  logic [30:0] val0, val1;
  c3s2_lane u_lane0 (.clk(clk), .en(en), .psum(win), .kern(kern[2:0]),
                     .bias(bias_0), .value(val0));
  c3s2_lane u_lane1 (.clk(clk), .en(en), .psum(win), .kern(kern[5:3]),
                     .bias(bias_1), .value(val1));

  // merge: lanes take the window alongside tag[0], values line up with tag[4]
  c3s2_pkg::result_t q [2];
  c3s2_pkg::result_t mres;
  wire push = en && vpipe[PIPE-1];
  wire pop  = out_valid && !out_stall;
  assign mres = '{out_value_0: val0, out_value_1: val1,
                  out_row: tag[PIPE-1].orow, out_col: tag[PIPE-1].ocol,
                  last_of_frame: tag[PIPE-1].last};

  always_ff @(posedge clk) begin
    if (rst) qcount <= '0;
    else qcount <= qcount + {1'b0, push} - {1'b0, pop};
    if (pop && push) begin
      if (qcount[1]) begin
        q[0] <= q[1];
        q[1] <= mres;
      end else begin
        q[0] <= mres;
      end
    end else if (pop) begin
      q[0] <= q[1];
    end else if (push) begin
      q[qcount[0]] <= mres;
    end
  end

  assign out_valid = qcount != 2'd0;
  assign out_data = q[0];
endmodule
`default_nettype wire

// ===== verif/tb_conv3x3_stride2_bias_relu_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_conv3x3_stride2_bias_relu_unit;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  c3s2_pkg::pixel_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  c3s2_pkg::result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [c3s2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [c3s2_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  conv3x3_stride2_bias_relu_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [47:0] kernel_rows [6];
  logic signed [31:0] biases [2];
  logic [23:0] row_buf [2][c3s2_pkg::LINE_WIDTH];
  logic [23:0] window [3][3];
  int col_pos, row_pos;

  c3s2_pkg::pixel_t pixels_pending[$];
  c3s2_pkg::result_t expected_windows[$];
  int send_idle_pct, recv_stall_pct;
  int error_count = 0;
  int cycles = 0;

  function automatic int channel_sum(logic [23:0] px);
    return int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16]);
  endfunction

  function automatic logic [30:0] filter_result(int f);
    longint acc;
    acc = 0;
    for (int k = 0; k < 3; k++)
      for (int l = 0; l < 3; l++)
        acc += longint'($signed(kernel_rows[f*3+k][16*l +: 16])) *
               longint'(channel_sum(window[k][l]));
    acc += longint'(biases[f]);
    if (acc <= 0) return '0;
    if (acc > 64'sd2147483647) return 31'h7FFFFFFF;
    return acc[30:0];
  endfunction

  task automatic predict_window(c3s2_pkg::pixel_t p);
    int r, c;
    logic [23:0] top, mid;
    c3s2_pkg::result_t res;
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    top = row_buf[0][c];
    mid = row_buf[1][c];
    for (int k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = window[k][2];
    end
    window[0][2] = top;
    window[1][2] = mid;
    window[2][2] = {p.red, p.green, p.blue};
    row_buf[0][c] = mid;
    row_buf[1][c] = {p.red, p.green, p.blue};
    col_pos = c + 1;
    if (col_pos >= c3s2_pkg::LINE_WIDTH) begin
      col_pos = 0;
      row_pos = (r + 1 >= c3s2_pkg::IMAGE_HEIGHT) ? 0 : r + 1;
    end
    if (r >= 2 && c >= 2 && (r % 2) == 0 && (c % 2) == 0 &&
        (r - 2) / 2 < c3s2_pkg::OUT_H && (c - 2) / 2 < c3s2_pkg::OUT_W) begin
      res.out_value_0 = filter_result(0);
      res.out_value_1 = filter_result(1);
      res.out_row = 5'((r - 2) / 2);
      res.out_col = 5'((c - 2) / 2);
      res.last_of_frame = ((r - 2) / 2 == c3s2_pkg::OUT_H - 1) &&
                          ((c - 2) / 2 == c3s2_pkg::OUT_W - 1);
      expected_windows.push_back(res);
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_window(in_data);
      if (!in_valid || !in_stall) begin
        if (pixels_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pixels_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          error_count++;
        end else begin
          c3s2_pkg::result_t e;
          e = expected_windows.pop_front();
          if (out_data.out_value_0 !== e.out_value_0) begin
            $display("%0t: out_value_0 exp %0d got %0d", $time, e.out_value_0,
                     out_data.out_value_0);
            error_count++;
          end
          if (out_data.out_value_1 !== e.out_value_1) begin
            $display("%0t: out_value_1 exp %0d got %0d", $time, e.out_value_1,
                     out_data.out_value_1);
            error_count++;
          end
          if (out_data.out_row !== e.out_row) begin
            $display("%0t: out_row exp %0d got %0d", $time, e.out_row, out_data.out_row);
            error_count++;
          end
          if (out_data.out_col !== e.out_col) begin
            $display("%0t: out_col exp %0d got %0d", $time, e.out_col, out_data.out_col);
            error_count++;
          end
          if (out_data.last_of_frame !== e.last_of_frame) begin
            $display("%0t: last_of_frame exp %0b got %0b", $time, e.last_of_frame,
                     out_data.last_of_frame);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(c3s2_pkg::cfg_reg_t idx, logic [47:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= c3s2_pkg::REG_F1_ROW2) kernel_rows[idx] = value;
    else biases[idx - c3s2_pkg::REG_BIAS_0] = value[31:0];
  endtask

  function automatic logic [47:0] rand_row(int mag);
    logic [47:0] v;
    for (int l = 0; l < 3; l++) v[16*l +: 16] = 16'($urandom_range(0, 2*mag) - mag);
    return v;
  endfunction

  task automatic write_random_setup(int mag);
    for (int i = 0; i < 6; i++) write_reg(c3s2_pkg::cfg_reg_t'(i), rand_row(mag));
    write_reg(c3s2_pkg::REG_BIAS_0, 48'($urandom()));
    write_reg(c3s2_pkg::REG_BIAS_1, 48'($signed($urandom_range(0, 200000)) - 100000));
  endtask

  task automatic add_random_pixels(int n, int fs_odds);
    c3s2_pkg::pixel_t p;
    for (int i = 0; i < n; i++) begin
      p.frame_start = (fs_odds != 0) && ($urandom_range(1, fs_odds) == 1);
      p.red = 8'($urandom());
      p.green = 8'($urandom());
      p.blue = 8'($urandom());
      pixels_pending.push_back(p);
    end
  endtask

  task automatic wait_idle();
    while (pixels_pending.size() != 0 || in_valid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    c3s2_pkg::pixel_t p;
    for (int i = 0; i < 6; i++) kernel_rows[i] = '0;
    biases[0] = '0;
    biases[1] = '0;
    for (int i = 0; i < c3s2_pkg::LINE_WIDTH; i++) begin
      row_buf[0][i] = '0;
      row_buf[1][i] = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int l = 0; l < 3; l++) window[k][l] = '0;
    col_pos = 0;
    row_pos = 0;
    send_idle_pct = 6;
    recv_stall_pct = 57;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // phase 1: random weights, directed extreme pixels, then random with rare restarts
    write_random_setup(32767);
    for (int i = 0; i < 20; i++) begin
      p.frame_start = (i == 0);
      p.red = (i % 2) ? 8'hFF : 8'h00;
      p.green = (i % 3) ? 8'hFF : 8'h00;
      p.blue = (i % 4) ? 8'h00 : 8'hFF;
      pixels_pending.push_back(p);
    end
    p = '{frame_start: 1'b1, red: 8'hFF, green: 8'hFF, blue: 8'hFF};
    pixels_pending.push_back(p);
    add_random_pixels(400, 0);
    add_random_pixels(300, 300);
    wait_idle();

    // phase 2: saturating weights and bias on filter 0, most negative on filter 1
    send_idle_pct = 57;
    recv_stall_pct = 6;
    for (int i = 0; i < 3; i++) write_reg(c3s2_pkg::cfg_reg_t'(i), {3{16'h7FFF}});
    for (int i = 3; i < 6; i++) write_reg(c3s2_pkg::cfg_reg_t'(i), {3{16'h8000}});
    write_reg(c3s2_pkg::REG_BIAS_0, 48'h0000_7FFF_FFFF);
    write_reg(c3s2_pkg::REG_BIAS_1, 48'h0000_8000_0000);
    p = '{frame_start: 1'b1, red: 8'h00, green: 8'h00, blue: 8'h00};
    pixels_pending.push_back(p);
    add_random_pixels(400, 400);
    wait_idle();

    // phase 3: small weights, full rate in both directions
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_random_setup(300);
    p = '{frame_start: 1'b1, red: 8'h12, green: 8'h34, blue: 8'h56};
    pixels_pending.push_back(p);
    add_random_pixels(9 * c3s2_pkg::LINE_WIDTH, 0);
    wait_idle();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
